/* rtl/core/psv_pkg.sv */
// Shared types, widths and constants for the position servo core.
package psv_pkg;

    // Field and state widths
    localparam int DEG_W   = 16;
    localparam int POS_W   = 24;
    localparam int GAIN_W  = 16;
    localparam int CNT_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int SP_W    = 40;
    localparam int E_W     = 34;
    localparam int DE_W    = 35;
    localparam int INT_W   = 18;
    localparam int WHOLE_W = E_W - 8;
    localparam int CONV_W  = 31;
    localparam int DUTY_W  = 10;
    localparam int KP_W    = GAIN_W + 1 + E_W;
    localparam int KD_W    = GAIN_W + 1 + DE_W;
    localparam int KIM_W   = 33;
    localparam int KD1K_W  = 62;
    localparam int PD_W    = 63;
    localparam int KIT_W   = 32;
    localparam int SUM_W   = 64;

    // Item kinds on the input stream
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_KP         = 3'd0;
    localparam logic [2:0] CFG_KI         = 3'd1;
    localparam logic [2:0] CFG_KD         = 3'd2;
    localparam logic [2:0] CFG_PPR        = 3'd3;
    localparam logic [2:0] CFG_TOL        = 3'd4;
    localparam logic [2:0] CFG_SETTLE     = 3'd5;
    localparam logic [2:0] CFG_TIMEOUT    = 3'd6;
    localparam logic [2:0] CFG_MIN_DRIVE  = 3'd7;

    // Arithmetic constants
    localparam logic signed [INT_W-1:0] INTEG_LIMIT   = 18'sd100000;
    localparam logic signed [SUM_W-1:0] OUT_LIMIT_Q20 = 64'sd267386880;
    // floor(2^32 * 32/45): degrees*ppr*256/360 as a reciprocal multiply
    localparam logic [31:0] SP_RECIP   = 32'd3054198966;
    // floor(2^32 * 32/125): integral term *256/1000
    localparam logic [30:0] KI_RECIP   = 31'd1099511627;
    // 999*257: m*999/255 through 1/255 = 257/65535
    localparam logic [25:0] DUTY_RECIP = 26'd256743;
    localparam logic [17:0] DUTY_TOP   = 18'd999;

    typedef enum logic [1:0] {
        ST_MOVING  = 2'd0,
        ST_SETTLED = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_IDLE    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } t_dir;

    typedef struct packed {
        logic [GAIN_W-1:0] kp_gain;
        logic [GAIN_W-1:0] ki_gain;
        logic [GAIN_W-1:0] kd_gain;
        logic [GAIN_W-1:0] pulses_per_rev;
        logic [BYTE_W-1:0] settle_tolerance;
        logic [CNT_W-1:0]  settle_ticks;
        logic [CNT_W-1:0]  timeout_ticks;
        logic [BYTE_W-1:0] min_drive;
    } t_cfg;

    // Front end to PID datapath
    typedef struct packed {
        logic                    pid;
        t_status                 status;
        logic signed [E_W-1:0]   e;
        logic signed [DE_W-1:0]  de;
        logic signed [INT_W-1:0] integ;
    } t_pid_item;

    // PID datapath to drive stage
    typedef struct packed {
        t_status           status;
        t_dir              dir;
        logic [BYTE_W-1:0] mag;
    } t_drv_item;

    // Final result
    typedef struct packed {
        t_status           status;
        logic [DUTY_W-1:0] duty;
        t_dir              dir;
    } t_result;

endpackage

/* rtl/core/pid_position_servo_core.sv */
// Top level of the encoder position servo: streams, config port and datapath.
// A start beat converts a target angle to a Q.8 pulse setpoint and arms a move;
// each tick beat takes the encoder count and returns direction, PWM duty
// (0..999) and move status. Every beat yields exactly one result beat. Tick
// beats are taken one per cycle while the pipeline is not stalled; after a
// start beat the input holds off while the setpoint reciprocal multiply and
// its correction finish, since the next tick reads that setpoint.
// Data on both streams comes straight from registers; ready ripples back
// through the stages, so a waiting result does not block input while any
// pipeline stage is free. Write the config port only while idle.
module pid_position_servo_core import psv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [15:0] target_deg, [39:16] position_count
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] drive_dir, [11:2] duty, [13:12] move_status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg      cfg;
    logic      item_valid, item_ready;
    t_pid_item item;
    logic      drv_valid, drv_ready;
    t_drv_item drv;
    t_result   res;

    psv_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    psv_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_in_valid       (s_axis_tvalid),
        .o_in_ready       (s_axis_tready),
        .i_func           (s_axis_tuser),
        .i_target_deg     ($signed(s_axis_tdata[15:0])),
        .i_position_count ($signed(s_axis_tdata[39:16])),
        .o_item_valid     (item_valid),
        .i_item_ready     (item_ready),
        .o_item           (item)
    );

    psv_pid u_pid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (item_valid),
        .o_item_ready (item_ready),
        .i_item       (item),
        .o_drv_valid  (drv_valid),
        .i_drv_ready  (drv_ready),
        .o_drv        (drv)
    );

    psv_drive u_drive (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_drv_valid (drv_valid),
        .o_drv_ready (drv_ready),
        .i_drv       (drv),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    // Result beat packing
    assign m_axis_tdata = {2'b00, res.status, res.duty, res.dir};

endmodule

/* rtl/core/psv_cfg_regs.sv */
// Configuration register file for the servo core.
module psv_cfg_regs import psv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes, one beat per register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain          <= 16'd8192;
            r_cfg.ki_gain          <= 16'd2048;
            r_cfg.kd_gain          <= 16'd410;
            r_cfg.pulses_per_rev   <= 16'd600;
            r_cfg.settle_tolerance <= 8'd2;
            r_cfg.settle_ticks     <= 16'd50;
            r_cfg.timeout_ticks    <= 16'd6000;
            r_cfg.min_drive        <= 8'd35;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KP:        r_cfg.kp_gain          <= i_cfg_data;
                CFG_KI:        r_cfg.ki_gain          <= i_cfg_data;
                CFG_KD:        r_cfg.kd_gain          <= i_cfg_data;
                CFG_PPR:       r_cfg.pulses_per_rev   <= i_cfg_data;
                CFG_TOL:       r_cfg.settle_tolerance <= i_cfg_data[BYTE_W-1:0];
                CFG_SETTLE:    r_cfg.settle_ticks     <= i_cfg_data;
                CFG_TIMEOUT:   r_cfg.timeout_ticks    <= i_cfg_data;
                CFG_MIN_DRIVE: r_cfg.min_drive        <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* rtl/core/psv_front.sv */
// Input register, move state, error/integral update and setpoint conversion.
module psv_front import psv_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_func,
    input  logic signed [DEG_W-1:0] i_target_deg,
    input  logic signed [POS_W-1:0] i_position_count,
    output logic                    o_item_valid,
    input  logic                    i_item_ready,
    output t_pid_item               o_item
);

    // Input register
    logic                    r_in_v;
    logic                    r_in_func;
    logic signed [DEG_W-1:0] r_in_deg;
    logic signed [POS_W-1:0] r_in_pos;

    // Output register
    logic      r_out_v;
    t_pid_item r_out;

    // Move state
    logic signed [SP_W-1:0]  r_sp;
    logic signed [INT_W-1:0] r_integ;
    logic signed [E_W-1:0]   r_last;
    logic [CNT_W-1:0]        r_run;
    logic [CNT_W-1:0]        r_elapsed;
    logic                    r_moving;

    // Setpoint conversion stages
    logic              r_c1_v;
    logic              r_c1_neg;
    logic [CONV_W-1:0] r_c1_mag;
    logic              r_c2_v;
    logic              r_c2_neg;
    logic [CONV_W-1:0] r_c2_mag;
    logic [CONV_W-1:0] r_c2_est;

    logic out_rdy;
    logic fire;
    logic in_is_start;

    // Handshake: a start holds off new beats until its setpoint lands
    assign out_rdy      = !r_out_v || i_item_ready;
    assign fire         = r_in_v && out_rdy;
    assign in_is_start  = r_in_v && (r_in_func == FUNC_START);
    assign o_in_ready   = (!r_in_v || fire) && !in_is_start && !r_c1_v;
    assign o_item_valid = r_out_v;
    assign o_item       = r_out;

    // Error in Q.8 and its whole-pulse part
    logic signed [SP_W-1:0]    pos_q8;
    logic signed [SP_W-1:0]    e_full;
    logic signed [E_W-1:0]     e;
    logic                      e_neg;
    logic [E_W-1:0]            e_mag;
    logic [WHOLE_W-1:0]        e_whole;
    logic signed [WHOLE_W:0]   ei;
    logic                      in_tol;
    logic [CNT_W-1:0]          run_inc;
    logic [CNT_W-1:0]          run_n;
    logic                      settle_done;
    logic                      timed_out;
    logic signed [WHOLE_W+1:0] integ_sum;
    logic signed [INT_W-1:0]   integ_n;
    logic signed [DE_W-1:0]    de;

    assign pos_q8  = {{(SP_W-POS_W-8){r_in_pos[POS_W-1]}}, r_in_pos, 8'd0};
    assign e_full  = r_sp - pos_q8;
    assign e       = e_full[E_W-1:0];
    assign e_neg   = e[E_W-1];
    assign e_mag   = e_neg ? E_W'(-e) : E_W'(e);
    assign e_whole = e_mag[E_W-1:8];
    assign ei      = e_neg ? -$signed({1'b0, e_whole}) : $signed({1'b0, e_whole});

    // Settle counting
    assign in_tol      = (e_whole <= WHOLE_W'(i_cfg.settle_tolerance));
    assign run_inc     = (r_run == '1) ? r_run : r_run + 16'd1;
    assign run_n       = in_tol ? run_inc : '0;
    assign settle_done = in_tol && (run_inc >= i_cfg.settle_ticks);
    assign timed_out   = (r_elapsed >= i_cfg.timeout_ticks);

    // Integral with anti-windup clamp
    assign integ_sum = (WHOLE_W+2)'(r_integ) + (WHOLE_W+2)'(ei);
    always_comb begin
        if (integ_sum > (WHOLE_W+2)'(INTEG_LIMIT)) begin
            integ_n = INTEG_LIMIT;
        end else if (integ_sum < -(WHOLE_W+2)'(INTEG_LIMIT)) begin
            integ_n = -INTEG_LIMIT;
        end else begin
            integ_n = integ_sum[INT_W-1:0];
        end
    end

    assign de = DE_W'(e) - DE_W'(r_last);

    // Setpoint conversion: |deg|*ppr, reciprocal estimate, one correction
    logic [DEG_W:0]     deg_abs;
    logic [31:0]        deg_prod;
    logic [63:0]        est_full;
    logic [CONV_W+4:0]  conv_rem;
    logic [CONV_W-1:0]  sp_mag;
    logic signed [SP_W-1:0] sp_new;

    assign deg_abs  = r_in_deg[DEG_W-1] ? (DEG_W+1)'(-$signed({r_in_deg[DEG_W-1], r_in_deg}))
                                        : {1'b0, r_in_deg};
    assign deg_prod = 32'(deg_abs) * 32'(i_cfg.pulses_per_rev);
    assign est_full = 64'(r_c1_mag) * 64'(SP_RECIP);
    assign conv_rem = {r_c2_mag, 5'd0} - (CONV_W+5)'(r_c2_est) * (CONV_W+5)'(45);
    assign sp_mag   = (conv_rem >= (CONV_W+5)'(45)) ? r_c2_est + 31'd1 : r_c2_est;
    assign sp_new   = r_c2_neg ? -$signed({(SP_W-CONV_W)'(0), sp_mag})
                               : $signed({(SP_W-CONV_W)'(0), sp_mag});

    // Input beat capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_in_ready) begin
            r_in_v <= i_in_valid;
        end else if (fire) begin
            r_in_v <= 1'b0;
        end
        if (o_in_ready) begin
            r_in_func <= i_func;
            r_in_deg  <= i_target_deg;
            r_in_pos  <= i_position_count;
        end
    end

    // Conversion pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
        end else begin
            r_c1_v <= fire && (r_in_func == FUNC_START);
            r_c2_v <= r_c1_v;
        end
        r_c1_neg <= r_in_deg[DEG_W-1];
        r_c1_mag <= deg_prod[CONV_W-1:0];
        r_c2_neg <= r_c1_neg;
        r_c2_mag <= r_c1_mag;
        r_c2_est <= est_full[CONV_W+31:32];
    end

    // Move state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v   <= 1'b0;
            r_sp      <= '0;
            r_integ   <= '0;
            r_last    <= '0;
            r_run     <= '0;
            r_elapsed <= '0;
            r_moving  <= 1'b0;
        end else begin
            if (out_rdy) begin
                r_out_v <= r_in_v;
            end
            if (r_c2_v) begin
                r_sp      <= sp_new;
                r_integ   <= '0;
                r_last    <= '0;
                r_run     <= '0;
                r_elapsed <= '0;
                r_moving  <= 1'b1;
            end else if (fire && (r_in_func == FUNC_TICK) && r_moving) begin
                if (timed_out) begin
                    r_moving <= 1'b0;
                end else begin
                    r_elapsed <= r_elapsed + 16'd1;
                    r_run     <= run_n;
                    if (settle_done) begin
                        r_moving <= 1'b0;
                    end else begin
                        r_integ <= integ_n;
                        r_last  <= e;
                    end
                end
            end
        end
    end

    // Result record for the datapath
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.e     <= e;
            r_out.de    <= de;
            r_out.integ <= integ_n;
            // PID step only on a moving tick that neither times out nor settles
            r_out.pid   <= (r_in_func == FUNC_TICK) && r_moving && !timed_out && !settle_done;
            if (r_in_func == FUNC_START) begin
                r_out.status <= ST_MOVING;
            end else if (!r_moving) begin
                r_out.status <= ST_IDLE;
            end else if (timed_out) begin
                r_out.status <= ST_TIMEOUT;
            end else if (settle_done) begin
                r_out.status <= ST_SETTLED;
            end else begin
                r_out.status <= ST_MOVING;
            end
        end
    end

endmodule

/* rtl/core/psv_pid.sv */
// PID products, integral scaling, sum, output clamp and minimum drive floor.
module psv_pid import psv_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_item_valid,
    output logic      o_item_ready,
    input  t_pid_item i_item,
    output logic      o_drv_valid,
    input  logic      i_drv_ready,
    output t_drv_item o_drv
);

    // Stage valids and ready chain
    logic r_v2, r_v3, r_v4, r_v5;
    logic rdy2, rdy3, rdy4, rdy5;

    assign rdy5         = !r_v5 || i_drv_ready;
    assign rdy4         = !r_v4 || rdy5;
    assign rdy3         = !r_v3 || rdy4;
    assign rdy2         = !r_v2 || rdy3;
    assign o_item_ready = rdy2;
    assign o_drv_valid  = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy2) r_v2 <= i_item_valid;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // Stage 2: gain products
    logic signed [KP_W-1:0]  kp_prod;
    logic signed [KD_W-1:0]  kd_prod;
    logic                    integ_neg;
    logic [INT_W-2:0]        integ_mag;
    logic [KIM_W-1:0]        ki_mag;

    assign kp_prod   = $signed({1'b0, i_cfg.kp_gain}) * i_item.e;
    assign kd_prod   = $signed({1'b0, i_cfg.kd_gain}) * i_item.de;
    assign integ_neg = i_item.integ[INT_W-1];
    assign integ_mag = integ_neg ? (INT_W-1)'(-i_item.integ) : i_item.integ[INT_W-2:0];
    assign ki_mag    = KIM_W'(i_cfg.ki_gain) * KIM_W'(integ_mag);

    logic                   r2_pid;
    t_status                r2_status;
    logic signed [KP_W-1:0] r2_kp;
    logic signed [KD_W-1:0] r2_kd;
    logic [KIM_W-1:0]       r2_ki_mag;
    logic                   r2_ki_neg;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_pid    <= i_item.pid;
            r2_status <= i_item.status;
            r2_kp     <= kp_prod;
            r2_kd     <= kd_prod;
            r2_ki_mag <= ki_mag;
            r2_ki_neg <= integ_neg;
        end
    end

    // Stage 3: derivative time scale and integral reciprocal estimate
    logic signed [KD1K_W-1:0] kd1000;
    logic [63:0]              ki_est_full;

    assign kd1000      = KD1K_W'(r2_kd) * $signed(11'sd1000);
    assign ki_est_full = 64'(r2_ki_mag) * 64'(KI_RECIP);

    logic                     r3_pid;
    t_status                  r3_status;
    logic signed [KP_W-1:0]   r3_kp;
    logic signed [KD1K_W-1:0] r3_kd;
    logic [KIM_W-1:0]         r3_ki_mag;
    logic                     r3_ki_neg;
    logic [30:0]              r3_ki_est;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_pid    <= r2_pid;
            r3_status <= r2_status;
            r3_kp     <= r2_kp;
            r3_kd     <= kd1000;
            r3_ki_mag <= r2_ki_mag;
            r3_ki_neg <= r2_ki_neg;
            r3_ki_est <= ki_est_full[62:32];
        end
    end

    // Stage 4: correct the integral quotient, add P and D
    logic [KIM_W+4:0]        ki_rem;
    logic [30:0]             ki_q;
    logic signed [KIT_W-1:0] ki_term;
    logic signed [PD_W-1:0]  pd;

    assign ki_rem = {r3_ki_mag, 5'd0} - (KIM_W+5)'(r3_ki_est) * (KIM_W+5)'(125);
    always_comb begin
        if (ki_rem >= (KIM_W+5)'(250)) begin
            ki_q = r3_ki_est + 31'd2;
        end else if (ki_rem >= (KIM_W+5)'(125)) begin
            ki_q = r3_ki_est + 31'd1;
        end else begin
            ki_q = r3_ki_est;
        end
    end
    assign ki_term = r3_ki_neg ? -$signed({1'b0, ki_q}) : $signed({1'b0, ki_q});
    assign pd      = PD_W'(r3_kp) + PD_W'(r3_kd);

    logic                    r4_pid;
    t_status                 r4_status;
    logic signed [PD_W-1:0]  r4_pd;
    logic signed [KIT_W-1:0] r4_ki;

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_pid    <= r3_pid;
            r4_status <= r3_status;
            r4_pd     <= pd;
            r4_ki     <= ki_term;
        end
    end

    // Stage 5: sum, clamp, truncate to whole output, apply floor
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] sum_c;
    logic                    u_neg;
    logic [28:0]             u_abs;
    logic [BYTE_W-1:0]       u_mag;

    assign sum = SUM_W'(r4_pd) + SUM_W'(r4_ki);
    always_comb begin
        if (sum > OUT_LIMIT_Q20) begin
            sum_c = OUT_LIMIT_Q20;
        end else if (sum < -OUT_LIMIT_Q20) begin
            sum_c = -OUT_LIMIT_Q20;
        end else begin
            sum_c = sum;
        end
    end
    assign u_neg = sum_c[SUM_W-1];
    assign u_abs = u_neg ? 29'(-sum_c[28:0]) : sum_c[28:0];
    assign u_mag = u_abs[27:20];

    t_drv_item r5;

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r5.status <= r4_status;
            if (!r4_pid || (u_mag == '0)) begin
                r5.dir <= DIR_STOP;
                r5.mag <= '0;
            end else begin
                r5.dir <= u_neg ? DIR_REV : DIR_FWD;
                r5.mag <= (u_mag < i_cfg.min_drive) ? i_cfg.min_drive : u_mag;
            end
        end
    end

    assign o_drv = r5;

endmodule

/* rtl/core/psv_drive.sv */
// Duty scaling m*999/255 and the output register.
module psv_drive import psv_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_drv_valid,
    output logic      o_drv_ready,
    input  t_drv_item i_drv,
    output logic      o_res_valid,
    input  logic      i_res_ready,
    output t_result   o_res
);

    logic r_v6, r_v7;
    logic rdy6, rdy7;

    assign rdy7        = !r_v7 || i_res_ready;
    assign rdy6        = !r_v6 || rdy7;
    assign o_drv_ready = rdy6;
    assign o_res_valid = r_v7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (rdy6) r_v6 <= i_drv_valid;
            if (rdy7) r_v7 <= r_v6;
        end
    end

    // Stage 6: exact product and reciprocal estimate
    logic [17:0] x999;
    logic [25:0] xr;

    assign x999 = 18'(i_drv.mag) * DUTY_TOP;
    assign xr   = 26'(i_drv.mag) * DUTY_RECIP;

    t_status           r6_status;
    t_dir              r6_dir;
    logic [17:0]       r6_x999;
    logic [DUTY_W-1:0] r6_q;

    always_ff @(posedge i_clk) begin
        if (rdy6) begin
            r6_status <= i_drv.status;
            r6_dir    <= i_drv.dir;
            r6_x999   <= x999;
            r6_q      <= xr[25:16];
        end
    end

    // Stage 7: one-step quotient correction
    logic [17:0] rem;
    t_result     r7;

    assign rem = r6_x999 - 18'(r6_q) * 18'd255;

    always_ff @(posedge i_clk) begin
        if (rdy7) begin
            r7.status <= r6_status;
            r7.dir    <= r6_dir;
            r7.duty   <= (rem >= 18'd255) ? r6_q + 10'd1 : r6_q;
        end
    end

    assign o_res = r7;

endmodule

/* tb/tb_top.sv */
// Self-checking bench for the position servo core: start and tick beats against a predicted drive.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import psv_pkg::*;

    localparam int     CLK_HALF   = 5;
    localparam int     DRAIN_MAX  = 5000;
    localparam int     LAT_PAD    = 12;
    localparam longint RUN_LIMIT  = 2_000_000;
    localparam longint INTEG_MAX  = 100000;
    localparam longint SUM_MAX    = 255 * 1048576;
    localparam longint Q20_SCALE  = 1048576;
    localparam longint POS_MAX    = 8388607;
    localparam longint POS_MIN    = -8388608;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // [15:0] target_deg, [39:16] position_count
    logic        s_axis_tuser = 1'b0; // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [1:0] drive_dir, [11:2] duty, [13:12] move_status
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    pid_position_servo_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Servo state mirrored by the predictor
    t_cfg   cfg_now;
    longint sp_q8;
    longint integ_acc;
    longint last_err_q8;
    int     settle_run;
    int     elapsed;
    bit     moving;

    t_result drive_cmd_q[$];
    int      errors = 0;
    int      burst_left = 0;

    function automatic t_cfg default_cfg();
        t_cfg c;
        c.kp_gain          = 16'd8192;
        c.ki_gain          = 16'd2048;
        c.kd_gain          = 16'd410;
        c.pulses_per_rev   = 16'd600;
        c.settle_tolerance = 8'd2;
        c.settle_ticks     = 16'd50;
        c.timeout_ticks    = 16'd6000;
        c.min_drive        = 8'd35;
        return c;
    endfunction

    // One servo step: updates the mirrored state, returns the drive command
    function automatic t_result compute_drive(input logic func,
                                              input logic signed [15:0] deg,
                                              input logic signed [23:0] pos);
        t_result r;
        longint  kp, ki, kd, e, mag, ei, integ, de, sum, u, m;
        kp = longint'(cfg_now.kp_gain);
        ki = longint'(cfg_now.ki_gain);
        kd = longint'(cfg_now.kd_gain);
        r.dir    = DIR_STOP;
        r.duty   = '0;
        r.status = ST_MOVING;

        // Start: new setpoint, clear the loop
        if (func == FUNC_START) begin
            sp_q8       = (longint'(deg) * longint'(cfg_now.pulses_per_rev) * 256) / 360;
            integ_acc   = 0;
            last_err_q8 = 0;
            settle_run  = 0;
            elapsed     = 0;
            moving      = 1'b1;
            return r;
        end
        if (!moving) begin
            r.status = ST_IDLE;
            return r;
        end
        // Timeout wins over settling
        if (longint'(elapsed) >= longint'(cfg_now.timeout_ticks)) begin
            moving   = 1'b0;
            r.status = ST_TIMEOUT;
            return r;
        end
        elapsed = (elapsed + 1) & 16'hFFFF;

        e   = sp_q8 - longint'(pos) * 256;
        mag = (e < 0) ? -e : e;
        ei  = (e < 0) ? -(mag / 256) : (mag / 256);

        // Settle counter, no PID step on the finishing tick
        if (mag / 256 <= longint'(cfg_now.settle_tolerance)) begin
            if (settle_run < 65535)
                settle_run++;
            if (longint'(settle_run) >= longint'(cfg_now.settle_ticks)) begin
                moving   = 1'b0;
                r.status = ST_SETTLED;
                return r;
            end
        end else begin
            settle_run = 0;
        end

        // Anti-windup integral
        integ = integ_acc + ei;
        if (integ > INTEG_MAX)
            integ = INTEG_MAX;
        if (integ < -INTEG_MAX)
            integ = -INTEG_MAX;
        integ_acc = integ;

        // PID sum in Q.20, 1 ms step
        de  = e - last_err_q8;
        sum = kp * e + kd * 1000 * de + (ki * integ * 256) / 1000;
        last_err_q8 = e;
        if (sum > SUM_MAX)
            sum = SUM_MAX;
        if (sum < -SUM_MAX)
            sum = -SUM_MAX;
        u = sum / Q20_SCALE;

        if (u == 0)
            return r;
        m = (u < 0) ? -u : u;
        if (m < longint'(cfg_now.min_drive))
            m = longint'(cfg_now.min_drive);
        r.dir  = (u > 0) ? DIR_FWD : DIR_REV;
        r.duty = 10'((m * 999) / 255);
        return r;
    endfunction

    // Send one input beat; bursts with random gaps in between
    task automatic send_item(input logic func, input logic [15:0] deg, input logic [23:0] pos);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {pos, deg};
        do @(posedge i_clk); while (!s_axis_tready);
        drive_cmd_q.push_back(compute_drive(func, deg, pos));
    endtask

    // Wait for all commands to come back, then let the pipeline go quiet
    task automatic drain_pipe();
        int k;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        for (k = 0; k < DRAIN_MAX && drive_cmd_q.size() != 0; k++)
            @(posedge i_clk);
        repeat (LAT_PAD) @(posedge i_clk);
        if (drive_cmd_q.size() != 0) begin
            $display("%0t: %0d expected drive beats never arrived", $realtime,
                     drive_cmd_q.size());
            errors++;
            drive_cmd_q.delete();
        end
    endtask

    // Config beat; valid stays high across back-to-back writes
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_KP:        cfg_now.kp_gain          = val;
            CFG_KI:        cfg_now.ki_gain          = val;
            CFG_KD:        cfg_now.kd_gain          = val;
            CFG_PPR:       cfg_now.pulses_per_rev   = val;
            CFG_TOL:       cfg_now.settle_tolerance = val[7:0];
            CFG_SETTLE:    cfg_now.settle_ticks     = val;
            CFG_TIMEOUT:   cfg_now.timeout_ticks    = val;
            CFG_MIN_DRIVE: cfg_now.min_drive        = val[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(input t_cfg c);
        write_reg(CFG_KP,        c.kp_gain);
        write_reg(CFG_KI,        c.ki_gain);
        write_reg(CFG_KD,        c.kd_gain);
        write_reg(CFG_PPR,       c.pulses_per_rev);
        write_reg(CFG_TOL,       c.settle_tolerance);
        write_reg(CFG_SETTLE,    c.settle_ticks);
        write_reg(CFG_TIMEOUT,   c.timeout_ticks);
        write_reg(CFG_MIN_DRIVE, c.min_drive);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(1024, 16384));
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 8192));
        endcase
    endfunction

    // First phase at the low end, last at the high end, the rest random
    function automatic t_cfg random_cfg(input int phase, input int last_phase);
        t_cfg c;
        if (phase == 0) begin
            c = '0;
            c.pulses_per_rev = 16'd1;
            c.settle_ticks   = 16'd1;
            c.timeout_ticks  = 16'd1;
            return c;
        end
        if (phase == last_phase) begin
            c = '1;
            return c;
        end
        c.kp_gain          = rand_gain();
        c.ki_gain          = rand_gain();
        c.kd_gain          = rand_gain();
        c.pulses_per_rev   = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(1, 65535))
                                                         : 16'($urandom_range(100, 4000));
        c.settle_tolerance = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(0, 8));
        c.settle_ticks     = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(1, 65535))
                                                         : 16'($urandom_range(1, 20));
        c.timeout_ticks    = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(1, 65535))
                                                         : 16'($urandom_range(5, 150));
        c.min_drive        = 8'($urandom);
        return c;
    endfunction

    function automatic logic [15:0] pick_target();
        if ($urandom_range(0, 4) != 0)
            return 16'(int'($urandom_range(0, 800)) - 400);
        return 16'($urandom);
    endfunction

    // Encoder count around the current setpoint: tracking, settled, far, or noise
    function automatic logic [23:0] pick_position(input int tol);
        longint centre, off, p;
        int     r;
        centre = sp_q8 / 256;
        r = $urandom_range(0, 99);
        if (r < 45)
            off = longint'($urandom_range(0, 400)) - 200;
        else if (r < 80)
            off = longint'($urandom_range(0, 2 * tol)) - tol;
        else if (r < 92)
            off = longint'($urandom_range(0, 200000)) - 100000;
        else
            return 24'($urandom);
        p = centre + off;
        if (p > POS_MAX)
            p = POS_MAX;
        if (p < POS_MIN)
            p = POS_MIN;
        return 24'(p);
    endfunction

    // Idle tick, then a short move at reset defaults
    task automatic test_idle_and_default();
        send_item(FUNC_TICK,  16'h1234, 24'd0);
        send_item(FUNC_START, 16'd90,   24'hABCDEF);
        send_item(FUNC_TICK,  16'hFFFF, 24'd0);
        send_item(FUNC_TICK,  16'h0000, 24'd300);
        send_item(FUNC_TICK,  16'h5A5A, 24'd150);
        drain_pipe();
    endtask

    // All gains and counts at full scale, angles and counts at their limits
    task automatic test_field_extremes();
        t_cfg c;
        c = '1;
        apply_cfg(c);
        send_item(FUNC_START, 16'h8000, 24'h000000);
        send_item(FUNC_TICK,  16'h0000, 24'h7FFFFF);
        send_item(FUNC_TICK,  16'hFFFF, 24'h800000);
        send_item(FUNC_START, 16'h7FFF, 24'hFFFFFF);
        send_item(FUNC_TICK,  16'h0000, 24'h800000);
        send_item(FUNC_TICK,  16'hFFFF, 24'h7FFFFF);
        drain_pipe();
    endtask

    // Zero pulses per rev; unit output raised to the drive floor; zero drive
    task automatic test_zero_setpoint_floor();
        t_cfg c;
        c = default_cfg();
        c.kp_gain          = 16'd4096;
        c.ki_gain          = 16'd0;
        c.kd_gain          = 16'd0;
        c.pulses_per_rev   = 16'd0;
        c.settle_tolerance = 8'd0;
        c.settle_ticks     = 16'hFFFF;
        c.timeout_ticks    = 16'hFFFF;
        apply_cfg(c);
        send_item(FUNC_START, 16'd100, 24'd0);
        send_item(FUNC_TICK,  16'd0,   24'hFFFFFF);
        send_item(FUNC_TICK,  16'd0,   24'd1);
        send_item(FUNC_TICK,  16'd0,   24'd0);
        drain_pipe();
    endtask

    // Zero settle count finishes on the first settled tick; zero timeout on the first tick
    task automatic test_immediate_finish();
        t_cfg c;
        c = default_cfg();
        c.settle_tolerance = 8'd0;
        c.settle_ticks     = 16'd0;
        apply_cfg(c);
        send_item(FUNC_START, 16'd0, 24'd0);
        send_item(FUNC_TICK,  16'd0, 24'd0);
        send_item(FUNC_TICK,  16'd0, 24'd0);
        drain_pipe();
        c = default_cfg();
        c.timeout_ticks = 16'd0;
        apply_cfg(c);
        send_item(FUNC_START, 16'd45, 24'd0);
        send_item(FUNC_TICK,  16'd0,  24'd0);
        send_item(FUNC_TICK,  16'd0,  24'd0);
        drain_pipe();
    endtask

    // Random moves: mostly starts followed by tracking ticks, some noise
    task automatic test_random_moves();
        localparam int PHASES    = 6;
        localparam int PER_PHASE = 100;
        t_cfg c;
        int   phase, sent, r;
        for (phase = 0; phase < PHASES; phase++) begin
            c = random_cfg(phase, PHASES - 1);
            apply_cfg(c);
            sent = 0;
            while (sent < PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (!moving && r >= 70) begin
                    send_item(FUNC_TICK, 16'($urandom), 24'($urandom));
                end else if (!moving || r < 4) begin
                    send_item(FUNC_START, pick_target(), 24'($urandom));
                    sent++;
                end else begin
                    send_item(FUNC_TICK, 16'($urandom), pick_position(c.settle_tolerance));
                    sent++;
                end
            end
            drain_pipe();
        end
    endtask

    // Result checker and receiver stall pattern
    t_rx_mode rx_mode = RX_OPEN;
    bit [31:0] rx_cyc = '0;

    always @(posedge i_clk) begin : rx_side
        t_result got, want;
        logic    rdy;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[13:0]);
            if (drive_cmd_q.size() == 0) begin
                $display("%0t: unexpected drive beat, actual dir %0d duty %0d status %0d",
                         $realtime, got.dir, got.duty, got.status);
                errors++;
            end else begin
                want = drive_cmd_q.pop_front();
                if (got.dir !== want.dir) begin
                    $display("%0t: drive_dir expected %0d actual %0d",
                             $realtime, want.dir, got.dir);
                    errors++;
                end
                if (got.duty !== want.duty) begin
                    $display("%0t: duty expected %0d actual %0d",
                             $realtime, want.duty, got.duty);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: move_status expected %0d actual %0d",
                             $realtime, want.status, got.status);
                    errors++;
                end
            end
        end
        rx_cyc++;
        if (rx_cyc[5:0] == 6'd0)
            rx_mode = t_rx_mode'($urandom_range(0, 2));
        case (rx_mode)
            RX_OPEN:   rdy = 1'b1;
            RX_RANDOM: rdy = ($urandom_range(0, 2) != 0);
            default:   rdy = (rx_cyc[2:0] < 3'd5);
        endcase
        m_axis_tready <= i_rst_n ? rdy : 1'b0;
    end

    // Run limit
    initial begin
        #(RUN_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        cfg_now     = default_cfg();
        sp_q8       = 0;
        integ_acc   = 0;
        last_err_q8 = 0;
        settle_run  = 0;
        elapsed     = 0;
        moving      = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_and_default();
        test_field_extremes();
        test_zero_setpoint_floor();
        test_immediate_finish();
        test_random_moves();

        drain_pipe();
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
